[rtl/adlr_pkg.sv]
// Shared types and constants for the audio downmix and linear resampler.
package adlr_pkg;

	localparam int CHANNELS  = 8;
	localparam int SAMPLE_W  = 16;
	localparam int CCOUNT_W  = 4;
	localparam int RATE_W    = 18;
	localparam int PHASE_W   = 20;
	localparam int SUM_W     = 19;
	localparam int PROD_W    = 35;
	localparam int ACC_W     = 36;
	localparam int NUM_W     = 35;
	localparam int DEN_W     = 19;
	localparam int QUO_W     = 17;
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W    = 5;
	localparam int EMIT_W    = 6;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [EMIT_W-1:0] RESULT_CAP = 6'd48;
	localparam logic [EMIT_W-1:0] LAST_SLOT  = 6'd47;

	localparam logic [CCOUNT_W-1:0] CCOUNT_MIN = 4'd1;
	localparam logic [CCOUNT_W-1:0] CCOUNT_MAX = 4'd8;
	localparam logic [CCOUNT_W-1:0] CCOUNT_RST = 4'd2;

	localparam logic [RATE_W-1:0] RATE_MIN  = 18'd8000;
	localparam logic [RATE_W-1:0] RATE_MAX  = 18'd192000;
	localparam logic [RATE_W-1:0] IRATE_RST = 18'd48000;
	localparam logic [RATE_W-1:0] ORATE_RST = 18'd16000;

	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [1:0] REG_INPUT_RATE    = 2'd1;
	localparam logic [1:0] REG_OUTPUT_RATE   = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] chan0_sample;
		logic signed [SAMPLE_W-1:0] chan1_sample;
		logic signed [SAMPLE_W-1:0] chan2_sample;
		logic signed [SAMPLE_W-1:0] chan3_sample;
		logic signed [SAMPLE_W-1:0] chan4_sample;
		logic signed [SAMPLE_W-1:0] chan5_sample;
		logic signed [SAMPLE_W-1:0] chan6_sample;
		logic signed [SAMPLE_W-1:0] chan7_sample;
		logic                       silent_frame;
		logic                       packet_end;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mono_sample;
		logic                       packet_last;
	} result_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_interp;
		logic cur_load;
		logic mul;
		logic add;
		logic push;
		logic push_rep;
		logic ph_sub;
		logic pop;
		logic pop_last;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic       ph_lt_orr;
		logic       rel_old;
		logic       rel_new;
		logic       end_frame;
		logic       silent;
		logic [1:0] qcnt;
		logic       out_free;
		logic       div_done;
	} status_t;

endpackage

[rtl/adlr_div.sv]
// Shared restoring divider, one quotient bit per cycle, rounded signed result.
module adlr_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [adlr_pkg::NUM_W-1:0]           num,
	input  logic [adlr_pkg::DEN_W-1:0]           den,
	input  logic                                 neg,
	output logic                                 done,
	output logic signed [adlr_pkg::SAMPLE_W-1:0] quo
);

	logic [adlr_pkg::NUM_W-1:0]  rem_q;
	logic [adlr_pkg::NUM_W-1:0]  dvs_q;
	logic [adlr_pkg::QUO_W-1:0]  quo_q;
	logic                        neg_q;
	logic [adlr_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;

	logic                        fits;
	logic [adlr_pkg::NUM_W-1:0]  diff;
	logic [adlr_pkg::QUO_W-1:0]  quo_signed;

	assign fits = rem_q >= dvs_q;
	assign diff = rem_q - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= adlr_pkg::STEP_W'(adlr_pkg::DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == adlr_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			// align divisor with the top quotient bit
			dvs_q <= adlr_pkg::NUM_W'(den) << (adlr_pkg::QUO_W - 1);
			quo_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff;
			end
			quo_q <= {quo_q[adlr_pkg::QUO_W-2:0], fits};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quo        = $signed(quo_signed[adlr_pkg::SAMPLE_W-1:0]);
	assign done       = done_q;

endmodule

[rtl/adlr_dp.sv]
// Datapath: downmix sum, interpolation products, phase, holding queue and result register.
module adlr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  adlr_pkg::cmd_t                cmd,
	output adlr_pkg::status_t             st,
	input  adlr_pkg::frame_t              frame_data,
	input  logic [adlr_pkg::CCOUNT_W-1:0] channel_count,
	input  logic [adlr_pkg::RATE_W-1:0]   input_rate,
	input  logic [adlr_pkg::RATE_W-1:0]   output_rate,
	output logic                          result_valid,
	output adlr_pkg::result_t             result_data,
	input  logic                          result_stall
);

	localparam int PHX_W = adlr_pkg::PHASE_W + 1;

	logic signed [adlr_pkg::SAMPLE_W-1:0] chan [adlr_pkg::CHANNELS];
	logic signed [adlr_pkg::SUM_W-1:0]    frame_sum;

	logic signed [adlr_pkg::SUM_W-1:0]    sum_q;
	logic                                 silent_q;
	logic                                 end_q;
	logic signed [adlr_pkg::SAMPLE_W-1:0] cur_q;
	logic signed [adlr_pkg::SAMPLE_W-1:0] prev_q;
	logic                                 have_prev_q;
	logic [adlr_pkg::PHASE_W-1:0]         phase_q;
	logic [adlr_pkg::PHASE_W-1:0]         ph_q;
	logic signed [adlr_pkg::PROD_W-1:0]   prod_a_s1;
	logic signed [adlr_pkg::PROD_W-1:0]   prod_b_s1;
	logic signed [adlr_pkg::ACC_W-1:0]    acc_s2;
	logic signed [adlr_pkg::SAMPLE_W-1:0] qv0_q;
	logic signed [adlr_pkg::SAMPLE_W-1:0] qv1_q;
	logic [1:0]                           qcnt_q;
	logic [adlr_pkg::EMIT_W-1:0]          emit_cnt_q;
	logic                                 result_valid_q;
	adlr_pkg::result_t                    result_q;

	logic [adlr_pkg::SUM_W-1:0]           sum_mag;
	logic [adlr_pkg::ACC_W-1:0]           acc_mag;
	logic [adlr_pkg::NUM_W-1:0]           div_num;
	logic [adlr_pkg::DEN_W-1:0]           div_den;
	logic                                 div_neg;
	logic                                 div_done;
	logic signed [adlr_pkg::SAMPLE_W-1:0] div_quo;
	logic [adlr_pkg::RATE_W-1:0]          ph_gap;
	logic signed [adlr_pkg::PROD_W-1:0]   mul_a;
	logic signed [adlr_pkg::PROD_W-1:0]   mul_b;
	logic [PHX_W-1:0]                     ph_plus_ir;
	logic [PHX_W-1:0]                     orr_plus_ir;
	logic [adlr_pkg::PHASE_W-1:0]         orr_w;
	logic signed [adlr_pkg::SAMPLE_W-1:0] item;
	logic                                 emit_req;
	logic                                 emit_ok;
	logic                                 emit_flag;

	assign chan[0] = frame_data.chan0_sample;
	assign chan[1] = frame_data.chan1_sample;
	assign chan[2] = frame_data.chan2_sample;
	assign chan[3] = frame_data.chan3_sample;
	assign chan[4] = frame_data.chan4_sample;
	assign chan[5] = frame_data.chan5_sample;
	assign chan[6] = frame_data.chan6_sample;
	assign chan[7] = frame_data.chan7_sample;

	always_comb begin
		frame_sum = '0;
		for (int i = 0; i < adlr_pkg::CHANNELS; i++) begin
			if (adlr_pkg::CCOUNT_W'(i) < channel_count) begin
				frame_sum = frame_sum + adlr_pkg::SUM_W'(chan[i]);
			end
		end
	end

	// rounding divide: (2|n| + d) / (2d), sign applied afterward
	assign sum_mag = sum_q[adlr_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign acc_mag = acc_s2[adlr_pkg::ACC_W-1] ? (~acc_s2 + 1'b1) : acc_s2;

	always_comb begin
		if (cmd.div_interp) begin
			div_num = {acc_mag[adlr_pkg::NUM_W-2:0], 1'b0} + adlr_pkg::NUM_W'(output_rate);
			div_den = {output_rate, 1'b0};
			div_neg = acc_s2[adlr_pkg::ACC_W-1];
		end else begin
			div_num = adlr_pkg::NUM_W'({sum_mag, 1'b0}) + adlr_pkg::NUM_W'(channel_count);
			div_den = adlr_pkg::DEN_W'({channel_count, 1'b0});
			div_neg = sum_q[adlr_pkg::SUM_W-1];
		end
	end

	adlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.neg    (div_neg),
		.done   (div_done),
		.quo    (div_quo)
	);

	// phase is below output_rate whenever the products are formed
	assign ph_gap = output_rate - ph_q[adlr_pkg::RATE_W-1:0];
	assign mul_a  = prev_q * $signed({1'b0, ph_gap});
	assign mul_b  = cur_q * $signed({1'b0, ph_q[adlr_pkg::RATE_W-1:0]});

	assign orr_w       = adlr_pkg::PHASE_W'(output_rate);
	assign ph_plus_ir  = PHX_W'(ph_q) + PHX_W'(input_rate);
	assign orr_plus_ir = PHX_W'(output_rate) + PHX_W'(input_rate);

	assign item = cmd.push_rep ? cur_q : div_quo;

	assign emit_req  = (cmd.push && (qcnt_q == 2'd2)) || cmd.pop;
	assign emit_ok   = emit_req && (emit_cnt_q < adlr_pkg::RESULT_CAP);
	assign emit_flag = end_q && ((emit_cnt_q == adlr_pkg::LAST_SLOT) || (cmd.pop && cmd.pop_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q    <= 1'b0;
			phase_q        <= '0;
			prev_q         <= '0;
			qcnt_q         <= '0;
			emit_cnt_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit_ok) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			if (cmd.load) begin
				emit_cnt_q <= '0;
			end else if (emit_ok) begin
				emit_cnt_q <= emit_cnt_q + 1'b1;
			end

			if (cmd.push) begin
				case (qcnt_q)
					2'd0: qcnt_q <= 2'd1;
					2'd1: qcnt_q <= 2'd2;
					default: qcnt_q <= 2'd2;
				endcase
			end else if (cmd.pop) begin
				qcnt_q <= qcnt_q - 1'b1;
			end else if (cmd.commit && end_q) begin
				qcnt_q <= '0;
			end

			if (cmd.commit) begin
				prev_q      <= cur_q;
				have_prev_q <= !end_q;
				phase_q     <= end_q ? '0 : ph_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q    <= frame_sum;
			silent_q <= frame_data.silent_frame;
			end_q    <= frame_data.packet_end;
			cur_q    <= '0;
			ph_q     <= have_prev_q ? phase_q : orr_w;
		end else begin
			if (cmd.cur_load) begin
				cur_q <= div_quo;
			end
			if (cmd.push) begin
				ph_q <= ph_plus_ir[adlr_pkg::PHASE_W-1:0];
			end else if (cmd.ph_sub) begin
				ph_q <= ph_q - orr_w;
			end
		end

		if (cmd.mul) begin
			prod_a_s1 <= mul_a;
			prod_b_s1 <= mul_b;
		end
		if (cmd.add) begin
			acc_s2 <= adlr_pkg::ACC_W'(prod_a_s1) + adlr_pkg::ACC_W'(prod_b_s1);
		end

		// full queue: oldest leaves as the new one enters
		if (cmd.push) begin
			case (qcnt_q)
				2'd0: qv0_q <= item;
				2'd1: qv1_q <= item;
				default: begin
					qv0_q <= qv1_q;
					qv1_q <= item;
				end
			endcase
		end else if (cmd.pop) begin
			qv0_q <= qv1_q;
		end

		if (emit_ok) begin
			result_q.mono_sample <= qv0_q;
			result_q.packet_last <= emit_flag;
		end
	end

	always_comb begin
		st.ph_lt_orr = ph_q < orr_w;
		st.rel_old   = end_q ? (PHX_W'(ph_q) <= orr_plus_ir) : (ph_q <= orr_w);
		st.rel_new   = end_q ? (ph_q <= orr_w) : (ph_plus_ir <= PHX_W'(output_rate));
		st.end_frame = end_q;
		st.silent    = silent_q;
		st.qcnt      = qcnt_q;
		st.out_free  = !result_valid_q || !result_stall;
		st.div_done  = div_done;
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

[rtl/adlr_ctrl.sv]
// Controller: sequences downmix, interpolation, repeat and release for one frame.
module adlr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	input  adlr_pkg::status_t st,
	output adlr_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DMX     = 4'd1;
	localparam logic [3:0] S_DWAIT   = 4'd2;
	localparam logic [3:0] S_ICHK    = 4'd3;
	localparam logic [3:0] S_MUL     = 4'd4;
	localparam logic [3:0] S_ADD     = 4'd5;
	localparam logic [3:0] S_IDIV    = 4'd6;
	localparam logic [3:0] S_IWAIT   = 4'd7;
	localparam logic [3:0] S_PUSH    = 4'd8;
	localparam logic [3:0] S_RCHK    = 4'd9;
	localparam logic [3:0] S_FIN_OLD = 4'd10;
	localparam logic [3:0] S_FIN_NEW = 4'd11;
	localparam logic [3:0] S_COMMIT  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       rep_q;
	logic       rep_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rep_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rep_q   <= rep_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		rep_d   = rep_q;
		case (state_q)
			S_IDLE: begin
				if (frame_valid) begin
					cmd.load = 1'b1;
					rep_d    = 1'b0;
					state_d  = S_DMX;
				end
			end
			S_DMX: begin
				if (st.silent) begin
					state_d = S_ICHK;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DWAIT;
				end
			end
			S_DWAIT: begin
				if (st.div_done) begin
					cmd.cur_load = 1'b1;
					state_d      = S_ICHK;
				end
			end
			S_ICHK: begin
				if (st.ph_lt_orr) begin
					state_d = S_MUL;
				end else begin
					// rebase phase onto the new frame
					cmd.ph_sub = 1'b1;
					if (st.end_frame) begin
						rep_d   = 1'b1;
						state_d = S_RCHK;
					end else begin
						state_d = S_FIN_OLD;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_IDIV;
			end
			S_IDIV: begin
				cmd.div_start  = 1'b1;
				cmd.div_interp = 1'b1;
				state_d        = S_IWAIT;
			end
			S_IWAIT: begin
				if (st.div_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (st.out_free) begin
					cmd.push     = 1'b1;
					cmd.push_rep = rep_q;
					state_d      = rep_q ? S_RCHK : S_ICHK;
				end
			end
			S_RCHK: begin
				state_d = st.ph_lt_orr ? S_PUSH : S_FIN_OLD;
			end
			S_FIN_OLD: begin
				if (st.qcnt == 2'd2) begin
					if (st.rel_old) begin
						if (st.out_free) begin
							cmd.pop      = 1'b1;
							cmd.pop_last = !st.rel_new;
							state_d      = S_FIN_NEW;
						end
					end else begin
						state_d = S_COMMIT;
					end
				end else begin
					state_d = S_FIN_NEW;
				end
			end
			S_FIN_NEW: begin
				if ((st.qcnt == 2'd1) && st.rel_new) begin
					if (st.out_free) begin
						cmd.pop      = 1'b1;
						cmd.pop_last = 1'b1;
						state_d      = S_COMMIT;
					end
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign frame_stall = state_q != S_IDLE;

endmodule

[rtl/audio_downmix_linear_resampler_core.sv]
// Top level: configuration registers, controller and datapath of the downmix resampler.
//
// Each accepted frame is averaged to mono over the first channel_count channels
// (rounded to nearest, ties away from zero) and the packet's mono stream is
// resampled by linear interpolation, with output positions tracked exactly by a
// phase scaled by output_rate; positions past a packet's last frame repeat it.
// Up to two computed outputs are held back until it is known whether they
// exist and which one ends the packet, so packet_last is exact. One frame is
// processed at a time: a divide for the downmix (skipped when silent), then per
// interpolated output a multiply, an add, a divide and a push, one push per
// repeated output, and a finish that releases held outputs and commits; pushes
// and releases wait while the result side stalls. The shared divider resolves
// one quotient bit per cycle over 17 steps. Configuration registers sit at byte
// offsets 0x0 (channel_count), 0x4 (input_rate) and 0x8 (output_rate); written
// values clamp to their legal range.
module audio_downmix_linear_resampler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  adlr_pkg::frame_t              frame_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output adlr_pkg::result_t             result_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [adlr_pkg::ADDR_W-1:0]   paddr,
	input  logic [adlr_pkg::DATA_W-1:0]   pwdata,
	output logic [adlr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [adlr_pkg::CCOUNT_W-1:0] ccount_q;
	logic [adlr_pkg::RATE_W-1:0]   irate_q;
	logic [adlr_pkg::RATE_W-1:0]   orate_q;

	logic                          wr_en;
	logic [1:0]                    reg_idx;
	logic [adlr_pkg::CCOUNT_W-1:0] wr_cc;
	logic [adlr_pkg::CCOUNT_W-1:0] sat_cc;
	logic [adlr_pkg::RATE_W-1:0]   wr_rate;
	logic [adlr_pkg::RATE_W-1:0]   sat_rate;

	adlr_pkg::cmd_t    cmd;
	adlr_pkg::status_t st;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign wr_cc   = pwdata[adlr_pkg::CCOUNT_W-1:0];
	assign wr_rate = pwdata[adlr_pkg::RATE_W-1:0];

	// clamp written values into range
	always_comb begin
		if (wr_cc < adlr_pkg::CCOUNT_MIN) begin
			sat_cc = adlr_pkg::CCOUNT_MIN;
		end else if (wr_cc > adlr_pkg::CCOUNT_MAX) begin
			sat_cc = adlr_pkg::CCOUNT_MAX;
		end else begin
			sat_cc = wr_cc;
		end
		if (wr_rate < adlr_pkg::RATE_MIN) begin
			sat_rate = adlr_pkg::RATE_MIN;
		end else if (wr_rate > adlr_pkg::RATE_MAX) begin
			sat_rate = adlr_pkg::RATE_MAX;
		end else begin
			sat_rate = wr_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccount_q <= adlr_pkg::CCOUNT_RST;
			irate_q  <= adlr_pkg::IRATE_RST;
			orate_q  <= adlr_pkg::ORATE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				adlr_pkg::REG_CHANNEL_COUNT: ccount_q <= sat_cc;
				adlr_pkg::REG_INPUT_RATE:    irate_q  <= sat_rate;
				adlr_pkg::REG_OUTPUT_RATE:   orate_q  <= sat_rate;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			adlr_pkg::REG_CHANNEL_COUNT: prdata = adlr_pkg::DATA_W'(ccount_q);
			adlr_pkg::REG_INPUT_RATE:    prdata = adlr_pkg::DATA_W'(irate_q);
			adlr_pkg::REG_OUTPUT_RATE:   prdata = adlr_pkg::DATA_W'(orate_q);
			default:                     prdata = '0;
		endcase
	end

	adlr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.st          (st),
		.cmd         (cmd)
	);

	adlr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.frame_data    (frame_data),
		.channel_count (ccount_q),
		.input_rate    (irate_q),
		.output_rate   (orate_q),
		.result_valid  (result_valid),
		.result_data   (result_data),
		.result_stall  (result_stall)
	);

endmodule
